[rtl/gdd_pkg.sv]
package gdd_pkg;

  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned COUNT_W   = 22;
  localparam int unsigned ORD_W     = 23;
  localparam int unsigned CENT_W    = 9;
  localparam int unsigned LEAPS_W   = 13;
  localparam int unsigned YDAY_W    = 9;

  localparam logic [YEAR_W-1:0]  MIN_YEAR_RESET = 14'd1900;
  localparam logic [COUNT_W-1:0] DAY_COUNT_MAX  = 22'd4194303;
  localparam logic [ORD_W-1:0]   DAYS_PER_YEAR  = 23'd365;

  // floor(x / 100) == (x * CENT_RECIP) >> CENT_SHIFT for every x below 2**15.
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int unsigned CENT_SHIFT = 19;
  localparam logic [14:0] CENT_DIV   = 15'd100;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } gdd_lane_en_t;

  typedef struct packed {
    logic             ok;
    logic [ORD_W-1:0] ordinal;
  } gdd_lane_res_t;

  function automatic logic [YDAY_W-1:0] gdd_days_before(input logic [MONTH_W-1:0] month);
    logic [YDAY_W-1:0] days;
    unique case (month)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  function automatic logic [DAY_W-1:0] gdd_month_len(input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[rtl/gdd_if.sv]
interface gdd_in_if;
  import gdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   first_day;
  logic [MONTH_W-1:0] first_month;
  logic [YEAR_W-1:0]  first_year;
  logic [DAY_W-1:0]   second_day;
  logic [MONTH_W-1:0] second_month;
  logic [YEAR_W-1:0]  second_year;

  modport source (
    output valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    output ready
  );
endinterface

interface gdd_out_if;
  import gdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] day_count;
  logic               invalid_date;

  modport source (
    output valid, day_count, invalid_date,
    input  ready
  );

  modport sink (
    input  valid, day_count, invalid_date,
    output ready
  );
endinterface

[rtl/gdd_lane.sv]
module gdd_lane (
  input  logic                         clk_i,
  input  gdd_pkg::gdd_lane_en_t        en_i,
  input  logic [gdd_pkg::DAY_W-1:0]    day_i,
  input  logic [gdd_pkg::MONTH_W-1:0]  month_i,
  input  logic [gdd_pkg::YEAR_W-1:0]   year_i,
  input  logic [gdd_pkg::YEAR_W-1:0]   min_year_i,
  output gdd_pkg::gdd_lane_res_t       res_o
);
  import gdd_pkg::*;

  // Stage 1: register the date and the rounded-up century count ceil(year / 100).
  logic [14:0]         year_p99;
  logic [27:0]         cent_prod;
  logic [CENT_W-1:0]   cent_d, cent_q;
  logic [DAY_W-1:0]    day_q;
  logic [MONTH_W-1:0]  month_q;
  logic [YEAR_W-1:0]   year_q;

  assign year_p99  = {1'b0, year_i} + 15'd99;
  assign cent_prod = {13'd0, year_p99} * {15'd0, CENT_RECIP};
  assign cent_d    = cent_prod[CENT_SHIFT +: CENT_W];

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      day_q   <= day_i;
      month_q <= month_i;
      year_q  <= year_i;
      cent_q  <= cent_d;
    end
  end

  // Stage 2: leap rule, date check, leap years before this year and day of year.
  logic [14:0]         cent_x100;
  logic                is_century;
  logic                leap;
  logic [14:0]         year_p3;
  logic [LEAPS_W-1:0]  q4;
  logic [LEAPS_W-1:0]  q400;
  logic [LEAPS_W-1:0]  leaps_d, leaps_q;
  logic [DAY_W-1:0]    month_len;
  logic [YDAY_W-1:0]   yday_d, yday_q;
  logic                ok_d, ok2_q;
  logic [YEAR_W-1:0]   year2_q;

  assign cent_x100  = {6'd0, cent_q} * CENT_DIV;
  assign is_century = (cent_x100 == {1'b0, year_q});
  // For a multiple of 100 the rounded-up century count is exact, so its low
  // two bits tell whether the year is also a multiple of 400.
  assign leap       = (year_q[1:0] == 2'b00) && (!is_century || (cent_q[1:0] == 2'b00));

  assign year_p3 = {1'b0, year_q} + 15'd3;
  assign q4      = year_p3[14:2];
  assign q400    = LEAPS_W'(({1'b0, cent_q} + 10'd3) >> 2);
  assign leaps_d = q4 - LEAPS_W'(cent_q) + q400;

  assign month_len = gdd_month_len(month_q) +
                     DAY_W'((month_q == MONTH_FEB) && leap);
  assign ok_d = (year_q >= min_year_i) && (month_q >= MONTH_JAN) &&
                (month_q <= MONTH_DEC) && (day_q != '0) && (day_q <= month_len);
  assign yday_d = gdd_days_before(month_q) + YDAY_W'(day_q) +
                  YDAY_W'((month_q >= MONTH_MAR) && leap);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      year2_q <= year_q;
      leaps_q <= leaps_d;
      yday_q  <= yday_d;
      ok2_q   <= ok_d;
    end
  end

  // Stage 3: ordinal day number of the date.
  logic [ORD_W-1:0] ordinal_d;

  assign ordinal_d = ORD_W'(year2_q) * DAYS_PER_YEAR + ORD_W'(leaps_q) + ORD_W'(yday_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      res_o.ordinal <= ordinal_d;
      res_o.ok      <= ok2_q;
    end
  end

endmodule

[rtl/gdd_merge.sv]
module gdd_merge (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  gdd_pkg::gdd_lane_res_t       res_a_i,
  input  gdd_pkg::gdd_lane_res_t       res_b_i,
  output logic [gdd_pkg::COUNT_W-1:0]  day_count_o,
  output logic                         invalid_date_o
);
  import gdd_pkg::*;

  logic [ORD_W-1:0]   diff_ab, diff_ba, diff_abs;
  logic               invalid_d;
  logic [COUNT_W-1:0] count_d;

  assign diff_ab   = res_a_i.ordinal - res_b_i.ordinal;
  assign diff_ba   = res_b_i.ordinal - res_a_i.ordinal;
  assign diff_abs  = (res_a_i.ordinal > res_b_i.ordinal) ? diff_ab : diff_ba;
  assign invalid_d = !res_a_i.ok || !res_b_i.ok;

  always_comb begin
    priority if (invalid_d) begin
      count_d = '0;
    end else if (diff_abs > ORD_W'(DAY_COUNT_MAX)) begin
      count_d = DAY_COUNT_MAX;
    end else begin
      count_d = diff_abs[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      day_count_o    <= count_d;
      invalid_date_o <= invalid_d;
    end
  end

endmodule

[rtl/gregorian_day_difference_top.sv]
// Gregorian day difference. Each input transaction carries two calendar dates
// and produces one output transaction with the absolute number of days between
// them, or a zero count with invalid_date set when either date is not a real
// date or lies before the programmed minimum year (reset value 1900). The block
// takes one transaction per clock cycle while out_o.ready does not hold the
// pipeline back; each result passes through four register stages: three in
// each of the two date lanes (century count, leap rule and date check, ordinal
// day) and the merge stage, whose output register holds the result. Counts
// above the 22-bit field saturate at its maximum.
// Write min_year only while no transaction is in flight.
module gregorian_day_difference_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gdd_pkg::YEAR_W-1:0]  cfg_wdata_i,
  gdd_in_if.sink                      in_i,
  gdd_out_if.source                   out_o
);
  import gdd_pkg::*;

  // Minimum valid year register.
  logic [YEAR_W-1:0] min_year_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MIN_YEAR_RESET;
    end else if (cfg_we_i) begin
      min_year_q <= cfg_wdata_i;
    end
  end

  // Pipeline occupancy. Each stage may load whenever it is empty or its content
  // moves on in the same cycle, so bubbles collapse and a waiting result in the
  // output register does not stop new transactions from entering while an
  // earlier stage still has room.
  logic [3:0] vld_d, vld_q;
  logic [3:0] rdy;

  assign rdy[3] = !vld_q[3] || out_o.ready;
  assign rdy[2] = !vld_q[2] || rdy[3];
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];

  assign vld_d[0] = rdy[0] ? in_i.valid : vld_q[0];
  assign vld_d[1] = rdy[1] ? vld_q[0]   : vld_q[1];
  assign vld_d[2] = rdy[2] ? vld_q[1]   : vld_q[2];
  assign vld_d[3] = rdy[3] ? vld_q[2]   : vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = rdy[0];
  assign out_o.valid = vld_q[3];

  // Stage load enables shared by both lanes: a stage captures new data only
  // when it has room and its upstream neighbor holds a valid transaction.
  gdd_lane_en_t lane_en;

  assign lane_en.s1 = rdy[0] && in_i.valid;
  assign lane_en.s2 = rdy[1] && vld_q[0];
  assign lane_en.s3 = rdy[2] && vld_q[1];

  // One lane per date; both run in lockstep.
  gdd_lane_res_t res_first, res_second;

  gdd_lane u_lane_first (
    .clk_i      (clk_i),
    .en_i       (lane_en),
    .day_i      (in_i.first_day),
    .month_i    (in_i.first_month),
    .year_i     (in_i.first_year),
    .min_year_i (min_year_q),
    .res_o      (res_first)
  );

  gdd_lane u_lane_second (
    .clk_i      (clk_i),
    .en_i       (lane_en),
    .day_i      (in_i.second_day),
    .month_i    (in_i.second_month),
    .year_i     (in_i.second_year),
    .min_year_i (min_year_q),
    .res_o      (res_second)
  );

  // The merge stage subtracts the two ordinals, saturates, and applies the
  // validity result; its register is the output register of the block.
  gdd_merge u_merge (
    .clk_i          (clk_i),
    .en_i           (rdy[3] && vld_q[2]),
    .res_a_i        (res_first),
    .res_b_i        (res_second),
    .day_count_o    (out_o.day_count),
    .invalid_date_o (out_o.invalid_date)
  );

endmodule
